@@ rtl/sstc_pkg.sv @@
// Shared constants and types for the subarray sum target counter.
// No dependencies; used by sstc_table and subarray_sum_target_counter.
`default_nettype none

package sstc_pkg;

  localparam int VALUE_W   = 32;
  localparam int KEY_W     = 48;
  localparam int COUNT_W   = 11;
  localparam int HERE_W    = 10;
  localparam int TOTAL_W   = 19;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;
  localparam logic [COUNT_W-1:0] HERE_MAX  = 11'd1023;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 19'd524287;

  localparam int DEF_TABLE_ENTRIES = 1024;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [COUNT_W-1:0] count_t;

endpackage

`default_nettype wire

@@ rtl/sstc_table.sv @@
// Prefix-sum table storage: key and count memories, one read and one write port.
// Depends on sstc_pkg for key and count types.
`default_nettype none

module sstc_table #(
  parameter int ENTRIES = sstc_pkg::DEF_TABLE_ENTRIES,
  parameter int IW      = $clog2(ENTRIES)
) (
  input  wire                   clk,
  input  wire                   rd_en,
  input  wire  [IW-1:0]         rd_addr,
  output sstc_pkg::key_t        rd_key,
  output sstc_pkg::count_t      rd_count,
  input  wire                   wr_en,
  input  wire  [IW-1:0]         wr_addr,
  input  sstc_pkg::key_t        wr_key,
  input  sstc_pkg::count_t      wr_count
);

  sstc_pkg::key_t   keys   [ENTRIES];
  sstc_pkg::count_t counts [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys[wr_addr]   <= wr_key;
      counts[wr_addr] <= wr_count;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key   <= keys[rd_addr];
      rd_count <= counts[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/subarray_sum_target_counter.sv @@
// Top level of the subarray sum target counter: control FSM, sums and result register.
// Depends on sstc_pkg and sstc_table.
//
//   channel   | handshake           | payload
//   ----------+---------------------+-------------------------------------------
//   cfg       | cfg_we              | cfg_data (target_sum)
//   input     | in_valid / in_stall | value, last
//   output    | out_valid/out_stall | matches_here, total_matches,
//             |                     | table_overflow, done_res
//
// The table is scanned one entry per cycle through the single memory read port; the
// scan is skipped when only key zero is present.
// Key zero lives in a register, so reset and end of sequence need no clearing pass.
// Reset (rst, synchronous) seeds the table and clears target_sum.
// A stalled result holds; the next item may be taken while it waits.
`default_nettype none

module subarray_sum_target_counter #(
  parameter int TABLE_ENTRIES = sstc_pkg::DEF_TABLE_ENTRIES
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire  [sstc_pkg::KEY_W-1:0]    cfg_data,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [sstc_pkg::VALUE_W-1:0]  value,
  input  wire                           last,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [sstc_pkg::HERE_W-1:0]   matches_here,
  output logic [sstc_pkg::TOTAL_W-1:0]  total_matches,
  output logic                          table_overflow,
  output logic                          done_res
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int UW = IW + 1;
  localparam logic [UW-1:0] FULL = UW'(TABLE_ENTRIES);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} state_t;

  state_t                  state;
  sstc_pkg::key_t          target;
  sstc_pkg::key_t          psum;
  sstc_pkg::key_t          want;
  logic                    last_q;
  logic                    hit_w;
  sstc_pkg::count_t        here_cnt;
  logic                    hit_p;
  logic                    hit_p_zero;
  logic [IW-1:0]           pos_p;
  sstc_pkg::count_t        cnt_p;
  logic [IW-1:0]           scan_idx;
  logic [IW-1:0]           rd_idx;
  logic                    rd_vld;
  logic [UW-1:0]           used;
  logic                    ovf;
  sstc_pkg::count_t        zero_count;
  logic [sstc_pkg::TOTAL_W-1:0] total;

  sstc_pkg::key_t          psum_next;
  sstc_pkg::key_t          want_next;
  logic                    accept;
  logic                    out_free;
  logic                    rd_en;
  sstc_pkg::key_t          rd_key;
  sstc_pkg::count_t        rd_count;
  logic                    wr_en;
  logic [IW-1:0]           wr_addr;
  sstc_pkg::count_t        wr_count;
  sstc_pkg::count_t        here_raw;
  logic [sstc_pkg::HERE_W-1:0]    here_sat;
  logic [sstc_pkg::TOTAL_W:0]     total_sum;
  logic [sstc_pkg::TOTAL_W-1:0]   total_next;
  logic [IW-1:0]           last_idx;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign out_free = !(out_valid && out_stall);
  assign last_idx = used[IW-1:0] - IW'(1);

  // prefix sum and lookup key, modulo 2^48
  assign psum_next = psum + {{(sstc_pkg::KEY_W-sstc_pkg::VALUE_W){value[sstc_pkg::VALUE_W-1]}},
                             value};
  assign want_next = psum_next - target;

  // scan reads
  assign rd_en = (state == S_SCAN);

  // final update: bump existing count or append a new key
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = pos_p;
    wr_count = (cnt_p < sstc_pkg::COUNT_MAX) ? cnt_p + 1'b1 : cnt_p;
    if ((state == S_FINISH) && out_free) begin
      if (hit_p) begin
        wr_en = !hit_p_zero;
      end else if (used != FULL) begin
        wr_en    = 1'b1;
        wr_addr  = used[IW-1:0];
        wr_count = sstc_pkg::count_t'(1);
      end
    end
  end

  // match count and saturated running total
  always_comb begin
    here_raw   = hit_w ? here_cnt : '0;
    here_sat   = (here_raw > sstc_pkg::HERE_MAX) ? sstc_pkg::HERE_MAX[sstc_pkg::HERE_W-1:0]
                                                  : here_raw[sstc_pkg::HERE_W-1:0];
    total_sum  = {1'b0, total} + {{(sstc_pkg::TOTAL_W+1-sstc_pkg::HERE_W){1'b0}}, here_sat};
    total_next = (total_sum > {1'b0, sstc_pkg::TOTAL_MAX}) ? sstc_pkg::TOTAL_MAX
                                                           : total_sum[sstc_pkg::TOTAL_W-1:0];
  end

  sstc_table #(
    .ENTRIES (TABLE_ENTRIES),
    .IW      (IW)
  ) u_table (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (scan_idx),
    .rd_key   (rd_key),
    .rd_count (rd_count),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_key   (psum),
    .wr_count (wr_count)
  );

  // control, state registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      target     <= '0;
      psum       <= '0;
      total      <= '0;
      used       <= UW'(1);
      ovf        <= 1'b0;
      zero_count <= sstc_pkg::count_t'(1);
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        target <= cfg_data;
      end
      // a result leaving while no new one is loaded
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      rd_vld <= rd_en;
      rd_idx <= scan_idx;

      // compare returned entry against both keys
      if (rd_vld && ((state == S_SCAN) || (state == S_DRAIN))) begin
        if (rd_key == want) begin
          hit_w    <= 1'b1;
          here_cnt <= rd_count;
        end
        if (rd_key == psum) begin
          hit_p <= 1'b1;
          pos_p <= rd_idx;
          cnt_p <= rd_count;
        end
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            psum       <= psum_next;
            want       <= want_next;
            last_q     <= last;
            hit_w      <= (want_next == '0);
            here_cnt   <= zero_count;
            hit_p      <= (psum_next == '0);
            hit_p_zero <= (psum_next == '0);
            cnt_p      <= zero_count;
            pos_p      <= '0;
            scan_idx   <= IW'(1);
            state      <= (used == UW'(1)) ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx + IW'(1);
          if (scan_idx == last_idx) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            matches_here   <= here_sat;
            total_matches  <= total_next;
            done_res       <= last_q;
            table_overflow <= ovf || (!hit_p && (used == FULL));
            if (last_q) begin
              psum       <= '0;
              total      <= '0;
              used       <= UW'(1);
              ovf        <= 1'b0;
              zero_count <= sstc_pkg::count_t'(1);
            end else begin
              total <= total_next;
              if (hit_p) begin
                if (hit_p_zero) begin
                  zero_count <= wr_count;
                end
              end else if (used != FULL) begin
                used <= used + UW'(1);
              end else begin
                ovf <= 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ verif/sstc_checker.sv @@
// Checker for the subarray sum target counter: watches the config, input and result channels.
// It predicts each result and compares it with the block's output. Depends on sstc_pkg.
module sstc_checker #(
  parameter int TABLE_ENTRIES = sstc_pkg::DEF_TABLE_ENTRIES
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [sstc_pkg::KEY_W-1:0]    cfg_data,
  input  wire                          in_valid,
  input  wire                          in_stall,
  input  wire [sstc_pkg::VALUE_W-1:0]  value,
  input  wire                          last,
  input  wire                          out_valid,
  input  wire                          out_stall,
  input  wire [sstc_pkg::HERE_W-1:0]   matches_here,
  input  wire [sstc_pkg::TOTAL_W-1:0]  total_matches,
  input  wire                          table_overflow,
  input  wire                          done_res,
  output int                           errors,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [sstc_pkg::HERE_W-1:0]  here;
    logic [sstc_pkg::TOTAL_W-1:0] total;
    logic                         ovf;
    logic                         done;
  } match_res_t;

  // Model state
  sstc_pkg::key_t   target;
  sstc_pkg::key_t   prefix;
  int               run_total;
  sstc_pkg::key_t   keys [TABLE_ENTRIES];
  sstc_pkg::count_t counts [TABLE_ENTRIES];
  int               used;
  logic             ovf_flag;
  match_res_t       match_q [$];

  function automatic void seed_sums();
    keys[0]   = '0;
    counts[0] = 1;
    used      = 1;
    prefix    = '0;
    run_total = 0;
    ovf_flag  = 1'b0;
  endfunction

  function automatic int find_prefix(sstc_pkg::key_t k);
    for (int i = 0; i < used; i++)
      if (keys[i] == k) return i;
    return -1;
  endfunction

  // Next result for one element; updates prefix sum and table
  function automatic match_res_t count_matches(logic [sstc_pkg::VALUE_W-1:0] v, logic l);
    match_res_t       r;
    int               pos;
    sstc_pkg::count_t here;
    here   = '0;
    prefix = prefix + {{(sstc_pkg::KEY_W-sstc_pkg::VALUE_W){v[sstc_pkg::VALUE_W-1]}}, v};
    pos    = find_prefix(prefix - target);
    if (pos >= 0) here = counts[pos];
    if (here > sstc_pkg::HERE_MAX) here = sstc_pkg::HERE_MAX;
    run_total = run_total + int'(here);
    if (run_total > int'(sstc_pkg::TOTAL_MAX)) run_total = int'(sstc_pkg::TOTAL_MAX);
    pos = find_prefix(prefix);
    if (pos >= 0) begin
      if (counts[pos] < sstc_pkg::COUNT_MAX) counts[pos] = counts[pos] + 1'b1;
    end else if (used < TABLE_ENTRIES) begin
      keys[used]   = prefix;
      counts[used] = 1;
      used++;
    end else begin
      ovf_flag = 1'b1;
    end
    r.here  = here[sstc_pkg::HERE_W-1:0];
    r.total = run_total[sstc_pkg::TOTAL_W-1:0];
    r.ovf   = ovf_flag;
    r.done  = l;
    if (l) seed_sums();
    return r;
  endfunction

  // Observe transfers on every channel
  always @(posedge clk) begin
    match_res_t want;
    if (rst) begin
      target = '0;
      seed_sums();
      match_q.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (cfg_we) target = cfg_data;
      if (in_valid && !in_stall) match_q.push_back(count_matches(value, last));
      if (out_valid && !out_stall) begin
        if (match_q.size() == 0) begin
          $display("%0t: unexpected result here=%0d total=%0d", $time, matches_here,
                   total_matches);
          errors++;
        end else begin
          want = match_q.pop_front();
          if (matches_here !== want.here) begin
            $display("%0t: matches_here expected %0d actual %0d", $time, want.here,
                     matches_here);
            errors++;
          end
          if (total_matches !== want.total) begin
            $display("%0t: total_matches expected %0d actual %0d", $time, want.total,
                     total_matches);
            errors++;
          end
          if (table_overflow !== want.ovf) begin
            $display("%0t: table_overflow expected %0b actual %0b", $time, want.ovf,
                     table_overflow);
            errors++;
          end
          if (done_res !== want.done) begin
            $display("%0t: done_res expected %0b actual %0b", $time, want.done, done_res);
            errors++;
          end
        end
      end
      pending = match_q.size();
    end
  end

endmodule

@@ verif/tb_subarray_sum_target_counter.sv @@
// Testbench top for the subarray sum target counter: clock, reset, stimulus and verdict.
// Depends on sstc_pkg, subarray_sum_target_counter and sstc_checker.
module tb_subarray_sum_target_counter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [sstc_pkg::KEY_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [sstc_pkg::VALUE_W-1:0]   value = '0;
  logic                           last = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [sstc_pkg::HERE_W-1:0]    matches_here;
  logic [sstc_pkg::TOTAL_W-1:0]   total_matches;
  logic                           table_overflow;
  logic                           done_res;
  int                             errors;
  int                             pending;

  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;
  bit  held = 1'b0;
  int  hold_left = 0;
  int  quiet = 0;
  int  items_sent = 0;
  int  seqs_sent = 0;

  subarray_sum_target_counter i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .value(value), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .matches_here(matches_here),
    .total_matches(total_matches), .table_overflow(table_overflow), .done_res(done_res)
  );

  sstc_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .value(value), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .matches_here(matches_here),
    .total_matches(total_matches), .table_overflow(table_overflow), .done_res(done_res),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !held && hold_left == 0) begin
      hold_left = 400;
      held      = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 15);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, quiet);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(logic [sstc_pkg::VALUE_W-1:0] v, logic l);
    if (idle_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    last     <= l;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (l) seqs_sent++;
  endtask

  // Drain, then write the target while the block is idle
  task automatic set_target(logic [sstc_pkg::KEY_W-1:0] t);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= t;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic run_zeros(int n);
    for (int i = 0; i < n; i++) send('0, i == n - 1);
  endtask

  // Random sequences, mostly small values so sums recur
  task automatic random_seqs(int n);
    int len;
    int k;
    logic [sstc_pkg::VALUE_W-1:0] v;
    k = 0;
    while (k < n) begin
      len = $urandom_range(1, 24);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) v = $urandom;
        else v = $signed($urandom_range(8)) - 4;
        send(v, i == len - 1 || $urandom_range(49) == 0);
        k++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes with target zero
    set_target('0);
    send(32'h7FFF_FFFF, 1'b0);
    send(32'h8000_0000, 1'b0);
    send(32'h0000_0001, 1'b0);
    send(32'hFFFF_FFFF, 1'b1);
    send(32'h0000_0000, 1'b1);
    send(32'h0000_0003, 1'b0);
    send(32'hFFFF_FFFD, 1'b1);
    // Target extremes, subtraction wraps
    set_target(48'h7FFF_FFFF_FFFF);
    send(32'h7FFF_FFFF, 1'b0);
    send(32'h8000_0000, 1'b0);
    send(32'h7FFF_FFFF, 1'b1);
    set_target(48'h8000_0000_0000);
    send(32'h8000_0000, 1'b0);
    send(32'h8000_0000, 1'b0);
    send(32'h7FFF_FFFF, 1'b1);
    set_target(48'hFFFF_FFFF_FFFF);
    send(32'hFFFF_FFFF, 1'b0);
    send(32'hFFFF_FFFF, 1'b0);
    send(32'h0000_0001, 1'b1);

    // Repeated zero prefix: key zero count climbs every element
    set_target('0);
    run_zeros(40);

    // Random phases over several targets
    set_target(48'd1);
    random_seqs(80);
    set_target(48'hFFFF_FFFF_FFFD);
    random_seqs(80);
    idle_on = 1'b0;
    set_target(48'd2);
    random_seqs(120);
    idle_on = 1'b1;
    set_target('0);
    hold_req = 1'b1;
    random_seqs(80);
    hold_req = 1'b0;
    // Sender waits for every result, then continues
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
    set_target(48'h0000_0000_0003);
    random_seqs(120);
    set_target({16'd0, 32'($urandom)});
    random_seqs(100);
    set_target(48'hFFFF_FFFF_FFFE);
    random_seqs(100);
    in_valid <= 1'b0;
    @(posedge clk);

    wait (pending == 0);
    repeat (200) @(posedge clk);
    $display("Ran %0d elements in %0d sequences over a dozen targets: value and target",
             items_sent, seqs_sent);
    $display("extremes, a zero-prefix run, random data with idle gaps and a long output hold.");
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
